// File: hw/rtl/texture_mip_chain_layout_defines.svh
// Assertion macros used by the top RTL file of the mip chain layout block.
`ifndef TEXTURE_MIP_CHAIN_LAYOUT_DEFINES_SVH
`define TEXTURE_MIP_CHAIN_LAYOUT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define TMCL_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tmcl assertion failed");

// Next-cycle implication, disabled while reset is high.
`define TMCL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tmcl assertion failed");

`endif

// File: hw/rtl/tmcl_pkg.sv
`default_nettype none
package tmcl_pkg;

   localparam logic [7:0]  BC_FORMAT_A = 8'd133;
   localparam logic [7:0]  BC_FORMAT_B = 8'd173;
   localparam logic [4:0]  TAIL_SLOTS  = 5'd8;
   localparam logic [31:0] TAIL_BYTES  = 32'd4096;
   localparam logic [33:0] U32_ALL     = 34'h0_FFFF_FFFF;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_BAD_DIM  = 2'd1,
      ST_BAD_ELEM = 2'd2,
      ST_OVERFLOW = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_FIND,
      S_TILE,
      S_TAIL,
      S_LIN,
      S_READ,
      S_OUT,
      S_ERR
   } state_type;

   typedef struct packed {
      logic [7:0]  format_code;
      logic [4:0]  element_bytes;
      logic [14:0] texel_width;
      logic [14:0] texel_height;
      logic [14:0] row_pitch;
      logic [4:0]  level_count;
   } req_payload_type;

   typedef struct packed {
      logic [14:0] elem_width;
      logic [14:0] elem_height;
      logic [14:0] tile_pitch;
      logic [31:0] tile_offset;
      logic [31:0] tile_size;
      logic        in_tail;
      logic [5:0]  tail_col;
      logic [5:0]  tail_row;
      logic [31:0] lin_offset;
      logic [31:0] lin_size;
      logic        last_level;
      status_type  status;
   } rsp_payload_type;

   typedef struct packed {
      logic [14:0] ew;
      logic [14:0] eh;
      logic [14:0] pw;
      logic [32:0] pad_sz;
      logic [32:0] lin_sz;
   } geom_type;

   typedef struct packed {
      logic [5:0] col;
      logic [5:0] row;
   } tail_pos_type;

   localparam tail_pos_type TAIL_POS [5][8] = '{
      '{'{6'd32, 6'd0}, '{6'd16, 6'd32}, '{6'd0, 6'd48}, '{6'd0, 6'd32},
        '{6'd16, 6'd16}, '{6'd16, 6'd0}, '{6'd0, 6'd16}, '{6'd0, 6'd0}},
      '{'{6'd32, 6'd0}, '{6'd16, 6'd16}, '{6'd0, 6'd24}, '{6'd0, 6'd16},
        '{6'd16, 6'd8}, '{6'd16, 6'd0}, '{6'd0, 6'd8}, '{6'd0, 6'd0}},
      '{'{6'd16, 6'd0}, '{6'd8, 6'd16}, '{6'd0, 6'd24}, '{6'd0, 6'd16},
        '{6'd8, 6'd8}, '{6'd8, 6'd0}, '{6'd0, 6'd8}, '{6'd0, 6'd0}},
      '{'{6'd16, 6'd0}, '{6'd8, 6'd8}, '{6'd0, 6'd12}, '{6'd0, 6'd8},
        '{6'd8, 6'd4}, '{6'd8, 6'd0}, '{6'd0, 6'd4}, '{6'd0, 6'd0}},
      '{'{6'd8, 6'd0}, '{6'd4, 6'd8}, '{6'd0, 6'd12}, '{6'd0, 6'd8},
        '{6'd4, 6'd4}, '{6'd4, 6'd0}, '{6'd0, 6'd4}, '{6'd0, 6'd0}}
   };

   function automatic logic [6:0] block_w(input logic [2:0] blog);
      logic [6:0] w;
      unique case (blog)
         3'd0, 3'd1: w = 7'd64;
         3'd2, 3'd3: w = 7'd32;
         default:    w = 7'd16;
      endcase
      return w;
   endfunction

   function automatic logic [6:0] block_h(input logic [2:0] blog);
      logic [6:0] h;
      unique case (blog)
         3'd0:       h = 7'd64;
         3'd1, 3'd2: h = 7'd32;
         default:    h = 7'd16;
      endcase
      return h;
   endfunction

endpackage
`default_nettype wire

// File: hw/rtl/texture_mip_chain_layout.sv
// Throughput: one request at a time. The check is followed by the level search, tile placement,
// tail placement and linear passes, one level per cycle, and then by the result beats, each read
// from the layout memory and held until rsp_ready; a 16384 texel side allows at most 15 levels.
// An error beat can come from the check or from the tile, tail or linear pass.
// Reset clears the sequencer and the first tail level; the layout memory is not cleared.
`default_nettype none
`include "texture_mip_chain_layout_defines.svh"
module texture_mip_chain_layout #(
   parameter int MAX_LEVELS = 16,
   parameter int MAX_DIM    = 16384
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire tmcl_pkg::req_payload_type  req_payload,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output tmcl_pkg::rsp_payload_type       rsp_payload
);

   localparam int AW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;

   tmcl_pkg::state_type       state_ff, state_in;
   tmcl_pkg::req_payload_type req_ff, req_in;
   tmcl_pkg::status_type      status_ff, status_in;
   logic [14:0] ew0_ff, ew0_in, eh0_ff, eh0_in;
   logic [2:0]  blog_ff, blog_in;
   logic [4:0]  lv_ff, lv_in, lvl_ff, lvl_in, ft_ff, ft_in;
   logic [33:0] toff_ff, toff_in, loff_ff, loff_in;

   logic        mem_wr, mem_rd;
   logic [63:0] mem_wdata, mem_rdata;
   logic [4:0]  geo_lvl;
   tmcl_pkg::geom_type geo;

   logic        dim_bad, elem_bad, shape_bad, is_bc;
   logic [2:0]  dec_blog;
   logic [15:0] ew0_c, eh0_c, pe0_c;
   logic [14:0] mmax;
   logic [4:0]  maxl;
   logic        fits;
   logic        tile_ovf, tail_bad, lin_ovf;
   logic [33:0] aligned;
   logic [2:0]  tail_idx;
   tmcl_pkg::tail_pos_type tpos;
   logic        rsp_fire, last;

   tmcl_mem #(.DEPTH(MAX_LEVELS), .AW(AW)) u_mem (
      .clock  (clock),
      .wr_en  (mem_wr),
      .wr_addr(geo_lvl[AW-1:0]),
      .wr_data(mem_wdata),
      .rd_en  (mem_rd),
      .rd_addr(lvl_ff[AW-1:0]),
      .rd_data(mem_rdata)
   );

   tmcl_geom u_geom (
      .ew0 (ew0_ff),
      .eh0 (eh0_ff),
      .lvl (geo_lvl[3:0]),
      .blog(blog_ff),
      .geo (geo)
   );

   always_comb begin
      is_bc = (req_ff.format_code == tmcl_pkg::BC_FORMAT_A) ||
              (req_ff.format_code == tmcl_pkg::BC_FORMAT_B);
      if (is_bc) begin
         ew0_c = (16'(req_ff.texel_width) + 16'd3) >> 2;
         eh0_c = (16'(req_ff.texel_height) + 16'd3) >> 2;
         pe0_c = (16'(req_ff.row_pitch) + 16'd3) >> 2;
      end else begin
         ew0_c = 16'(req_ff.texel_width);
         eh0_c = 16'(req_ff.texel_height);
         pe0_c = 16'(req_ff.row_pitch);
      end
      mmax = (req_ff.texel_width > req_ff.texel_height) ? req_ff.texel_width
                                                        : req_ff.texel_height;
      maxl = 5'd1;
      for (int i = 1; i < 15; i++) begin
         if (mmax[i]) begin
            maxl = 5'(i + 1);
         end
      end
      dim_bad = (req_ff.texel_width == 15'd0) || (req_ff.texel_height == 15'd0) ||
                (req_ff.row_pitch < req_ff.texel_width) || (req_ff.level_count == 5'd0) ||
                (32'(req_ff.level_count) > 32'(MAX_LEVELS)) ||
                (32'(req_ff.texel_width) > 32'(MAX_DIM)) ||
                (32'(req_ff.texel_height) > 32'(MAX_DIM));
      elem_bad = 1'b0;
      unique case (req_ff.element_bytes)
         5'd1:    dec_blog = 3'd0;
         5'd2:    dec_blog = 3'd1;
         5'd4:    dec_blog = 3'd2;
         5'd8:    dec_blog = 3'd3;
         5'd16:   dec_blog = 3'd4;
         default: begin
            dec_blog = 3'd0;
            elem_bad = 1'b1;
         end
      endcase
      shape_bad = (pe0_c != ew0_c) || (req_ff.level_count > maxl);
   end

   always_comb begin
      geo_lvl  = (state_ff == tmcl_pkg::S_TILE) ? lvl_ff - 5'd1 : lvl_ff;
      fits     = (16'(geo.ew) <= 16'(tmcl_pkg::block_w(blog_ff) >> 1)) &&
                 (16'(geo.eh) <= 16'(tmcl_pkg::block_h(blog_ff))) &&
                 ((lv_ff - lvl_ff) <= tmcl_pkg::TAIL_SLOTS);
      tile_ovf = (toff_ff + 34'(geo.pad_sz)) > tmcl_pkg::U32_ALL;
      tail_idx = 3'(lvl_ff - ft_ff);
      tpos     = tmcl_pkg::TAIL_POS[blog_ff][tail_idx];
      tail_bad = (16'(tpos.col) + 16'(geo.ew) > 16'(tmcl_pkg::block_w(blog_ff))) ||
                 (16'(tpos.row) + 16'(geo.eh) > 16'(tmcl_pkg::block_h(blog_ff)));
      aligned  = (loff_ff + 34'd3) & ~34'd3;
      lin_ovf  = (aligned + 34'(geo.lin_sz)) > tmcl_pkg::U32_ALL;
      rsp_fire = rsp_valid && rsp_ready;
      last     = (lvl_ff + 5'd1) == lv_ff;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tmcl_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = tmcl_pkg::S_CHECK;
            end
         end
         tmcl_pkg::S_CHECK: begin
            if (dim_bad || elem_bad || shape_bad) begin
               state_in = tmcl_pkg::S_ERR;
            end else if (req_ff.level_count > 5'd1) begin
               state_in = tmcl_pkg::S_FIND;
            end else begin
               state_in = tmcl_pkg::S_TILE;
            end
         end
         tmcl_pkg::S_FIND: begin
            if (fits && (lvl_ff == 5'd0)) begin
               state_in = tmcl_pkg::S_TAIL;
            end else if (fits || last) begin
               state_in = tmcl_pkg::S_TILE;
            end
         end
         tmcl_pkg::S_TILE: begin
            if (tile_ovf) begin
               state_in = tmcl_pkg::S_ERR;
            end else if (lvl_ff == 5'd1) begin
               state_in = tmcl_pkg::S_TAIL;
            end
         end
         tmcl_pkg::S_TAIL: begin
            if (lvl_ff == lv_ff) begin
               state_in = tmcl_pkg::S_LIN;
            end else if (tail_bad) begin
               state_in = tmcl_pkg::S_ERR;
            end
         end
         tmcl_pkg::S_LIN: begin
            if (lin_ovf) begin
               state_in = tmcl_pkg::S_ERR;
            end else if (last) begin
               state_in = tmcl_pkg::S_READ;
            end
         end
         tmcl_pkg::S_READ: state_in = tmcl_pkg::S_OUT;
         tmcl_pkg::S_OUT: begin
            if (rsp_ready) begin
               state_in = last ? tmcl_pkg::S_IDLE : tmcl_pkg::S_READ;
            end
         end
         tmcl_pkg::S_ERR: begin
            if (rsp_ready) begin
               state_in = tmcl_pkg::S_IDLE;
            end
         end
         default: state_in = tmcl_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      req_ready = (state_ff == tmcl_pkg::S_IDLE);
      rsp_valid = (state_ff == tmcl_pkg::S_OUT) || (state_ff == tmcl_pkg::S_ERR);
      mem_rd    = (state_ff == tmcl_pkg::S_READ);
      mem_wr    = ((state_ff == tmcl_pkg::S_TILE) && !tile_ovf) ||
                  ((state_ff == tmcl_pkg::S_TAIL) && (lvl_ff != lv_ff) && !tail_bad);
      mem_wdata = (state_ff == tmcl_pkg::S_TILE) ? {toff_ff[31:0], geo.pad_sz[31:0]}
                                                 : {32'd0, tmcl_pkg::TAIL_BYTES};
      if (state_ff == tmcl_pkg::S_ERR) begin
         rsp_payload            = '0;
         rsp_payload.last_level = 1'b1;
         rsp_payload.status     = status_ff;
      end else begin
         rsp_payload.elem_width  = geo.ew;
         rsp_payload.elem_height = geo.eh;
         rsp_payload.in_tail     = (lvl_ff >= ft_ff);
         rsp_payload.tile_pitch  = rsp_payload.in_tail ? 15'(tmcl_pkg::block_w(blog_ff))
                                                       : geo.pw;
         rsp_payload.tile_offset = mem_rdata[63:32];
         rsp_payload.tile_size   = mem_rdata[31:0];
         rsp_payload.tail_col    = rsp_payload.in_tail ? tpos.col : 6'd0;
         rsp_payload.tail_row    = rsp_payload.in_tail ? tpos.row : 6'd0;
         rsp_payload.lin_offset  = loff_ff[31:0];
         rsp_payload.lin_size    = geo.lin_sz[31:0];
         rsp_payload.last_level  = last;
         rsp_payload.status      = tmcl_pkg::ST_OK;
      end
   end

   always_comb begin
      req_in    = req_ff;
      status_in = status_ff;
      ew0_in    = ew0_ff;
      eh0_in    = eh0_ff;
      blog_in   = blog_ff;
      lv_in     = lv_ff;
      lvl_in    = lvl_ff;
      ft_in     = ft_ff;
      toff_in   = toff_ff;
      loff_in   = loff_ff;
      unique case (state_ff)
         tmcl_pkg::S_IDLE: req_in = req_payload;
         tmcl_pkg::S_CHECK: begin
            ew0_in  = ew0_c[14:0];
            eh0_in  = eh0_c[14:0];
            blog_in = dec_blog;
            lv_in   = req_ff.level_count;
            lvl_in  = (req_ff.level_count > 5'd1) ? 5'd0 : req_ff.level_count;
            ft_in   = req_ff.level_count;
            toff_in = '0;
            if (dim_bad) begin
               status_in = tmcl_pkg::ST_BAD_DIM;
            end else if (elem_bad) begin
               status_in = tmcl_pkg::ST_BAD_ELEM;
            end else begin
               status_in = tmcl_pkg::ST_BAD_DIM;
            end
         end
         tmcl_pkg::S_FIND: begin
            if (fits) begin
               ft_in   = lvl_ff;
               toff_in = 34'(tmcl_pkg::TAIL_BYTES);
            end else if (last) begin
               ft_in   = lv_ff;
               toff_in = '0;
               lvl_in  = lv_ff;
            end else begin
               lvl_in = lvl_ff + 5'd1;
            end
         end
         tmcl_pkg::S_TILE: begin
            status_in = tmcl_pkg::ST_OVERFLOW;
            toff_in   = toff_ff + 34'(geo.pad_sz);
            lvl_in    = (lvl_ff == 5'd1) ? ft_ff : lvl_ff - 5'd1;
         end
         tmcl_pkg::S_TAIL: begin
            status_in = tmcl_pkg::ST_OVERFLOW;
            loff_in   = '0;
            lvl_in    = (lvl_ff == lv_ff) ? 5'd0 : lvl_ff + 5'd1;
         end
         tmcl_pkg::S_LIN: begin
            status_in = tmcl_pkg::ST_OVERFLOW;
            loff_in   = last ? '0 : aligned + 34'(geo.lin_sz);
            lvl_in    = last ? 5'd0 : lvl_ff + 5'd1;
         end
         tmcl_pkg::S_READ: loff_in = aligned;
         tmcl_pkg::S_OUT: begin
            if (rsp_fire) begin
               loff_in = loff_ff + 34'(geo.lin_sz);
               lvl_in  = lvl_ff + 5'd1;
            end
         end
         tmcl_pkg::S_ERR: status_in = status_ff;
         default: status_in = status_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tmcl_pkg::S_IDLE;
         ft_ff    <= '0;
      end else begin
         state_ff <= state_in;
         ft_ff    <= ft_in;
      end
      req_ff    <= req_in;
      status_ff <= status_in;
      ew0_ff    <= ew0_in;
      eh0_ff    <= eh0_in;
      blog_ff   <= blog_in;
      lv_ff     <= lv_in;
      lvl_ff    <= lvl_in;
      toff_ff   <= toff_in;
      loff_ff   <= loff_in;
   end

   `TMCL_ASSERT_SAME(a_one_side, clock, reset, rsp_valid, !req_ready)
   `TMCL_ASSERT_SAME(a_out_level, clock, reset, state_ff == tmcl_pkg::S_OUT, lvl_ff < lv_ff)
   `TMCL_ASSERT_NEXT(a_req_check, clock, reset, req_valid && req_ready,
                     state_ff == tmcl_pkg::S_CHECK)
   `TMCL_ASSERT_NEXT(a_last_idle, clock, reset, rsp_fire && rsp_payload.last_level,
                     req_ready)
   `TMCL_ASSERT_SAME(a_wr_phase, clock, reset, mem_wr,
                     (state_ff == tmcl_pkg::S_TILE) || (state_ff == tmcl_pkg::S_TAIL))

endmodule
`default_nettype wire

// File: hw/rtl/tmcl_mem.sv
`default_nettype none
module tmcl_mem #(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [63:0]   wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic [63:0]        rd_data
);

   logic [63:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

// File: hw/rtl/tmcl_geom.sv
`default_nettype none
module tmcl_geom (
   input  wire logic [14:0] ew0,
   input  wire logic [14:0] eh0,
   input  wire logic [3:0]  lvl,
   input  wire logic [2:0]  blog,
   output tmcl_pkg::geom_type geo
);

   logic [16:0] round_add;
   logic [16:0] ew_sum;
   logic [16:0] eh_sum;
   logic [15:0] bw_m1;
   logic [15:0] bh_m1;
   logic [15:0] pw16;
   logic [15:0] ph16;
   logic [29:0] pad_prod;
   logic [29:0] lin_prod;

   always_comb begin
      round_add  = (17'd1 << lvl) - 17'd1;
      ew_sum     = 17'(ew0) + round_add;
      eh_sum     = 17'(eh0) + round_add;
      geo.ew     = 15'(ew_sum >> lvl);
      geo.eh     = 15'(eh_sum >> lvl);
      bw_m1      = 16'(tmcl_pkg::block_w(blog)) - 16'd1;
      bh_m1      = 16'(tmcl_pkg::block_h(blog)) - 16'd1;
      pw16       = (16'(geo.ew) + bw_m1) & ~bw_m1;
      ph16       = (16'(geo.eh) + bh_m1) & ~bh_m1;
      geo.pw     = 15'(pw16);
      pad_prod   = 30'(pw16[14:0]) * 30'(ph16[14:0]);
      lin_prod   = 30'(geo.ew) * 30'(geo.eh);
      geo.pad_sz = 33'(pad_prod) << blog;
      geo.lin_sz = 33'(lin_prod) << blog;
   end

endmodule
`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 100ps
`default_nettype none
module testbench;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   tmcl_pkg::req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   tmcl_pkg::rsp_payload_type rsp_payload;

   tmcl_pkg::req_payload_type pending_descs[$];
   tmcl_pkg::rsp_payload_type expected_levels[$];
   int error_count = 0;
   bit stimulus_done = 1'b0;
   int burst_left = 0;
   int gap_left = 0;
   int hold_cycles = 0;
   int accepted_count = 0;

   texture_mip_chain_layout dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload)
   );

   always #5 clock = ~clock;

   function automatic tmcl_pkg::rsp_payload_type layout_error(input tmcl_pkg::status_type code);
      tmcl_pkg::rsp_payload_type r;
      r = '0;
      r.last_level = 1'b1;
      r.status = code;
      return r;
   endfunction

   // Computes the level layouts of one texture description and queues them, or queues one error beat.
   task automatic predict_layout(input tmcl_pkg::req_payload_type d);
      logic [31:0] w, h, p, lv, bw, bh, blog, t, ew0, eh0, pe0, m, maxl, ft, idx, bpe;
      logic [31:0] ew[16], eh[16], tp[16], tx[16], ty[16], lo[16], ls[16];
      logic [63:0] toff, loff, sz, pw, ph;
      tmcl_pkg::rsp_payload_type r;
      w = d.texel_width; h = d.texel_height; p = d.row_pitch;
      lv = d.level_count; bpe = d.element_bytes;
      if (w == 0 || h == 0 || p < w || lv == 0 || lv > 16 || w > 16384 || h > 16384) begin
         expected_levels.push_back(layout_error(tmcl_pkg::ST_BAD_DIM));
         return;
      end
      case (bpe)
         1: begin bw = 64; bh = 64; blog = 0; end
         2: begin bw = 64; bh = 32; blog = 1; end
         4: begin bw = 32; bh = 32; blog = 2; end
         8: begin bw = 32; bh = 16; blog = 3; end
         16: begin bw = 16; bh = 16; blog = 4; end
         default: begin
            expected_levels.push_back(layout_error(tmcl_pkg::ST_BAD_ELEM));
            return;
         end
      endcase
      t = (d.format_code == tmcl_pkg::BC_FORMAT_A ||
           d.format_code == tmcl_pkg::BC_FORMAT_B) ? 4 : 1;
      ew0 = (w + t - 1) / t;
      eh0 = (h + t - 1) / t;
      pe0 = (p + t - 1) / t;
      m = w > h ? w : h;
      maxl = 1;
      while (m > 1) begin
         m = m >> 1;
         maxl++;
      end
      if (pe0 != ew0 || lv > maxl) begin
         expected_levels.push_back(layout_error(tmcl_pkg::ST_BAD_DIM));
         return;
      end
      for (int l = 0; l < lv; l++) begin
         ew[l] = (ew0 + (32'd1 << l) - 1) >> l;
         eh[l] = (eh0 + (32'd1 << l) - 1) >> l;
         tx[l] = 0; ty[l] = 0;
      end
      ft = lv;
      if (lv > 1) begin
         for (int l = 0; l < lv; l++) begin
            if (ew[l] <= (bw >> 1) && eh[l] <= bh && lv - l <= 8) begin
               ft = l;
               break;
            end
         end
      end
      toff = (ft < lv) ? 64'd4096 : 64'd0;
      for (int l = int'(ft) - 1; l >= 0; l--) begin
         pw = (ew[l] + bw - 1) & ~(bw - 1);
         ph = (eh[l] + bh - 1) & ~(bh - 1);
         sz = pw * ph * bpe;
         if (sz > 64'hFFFF_FFFF - toff) begin
            expected_levels.push_back(layout_error(tmcl_pkg::ST_OVERFLOW));
            return;
         end
         tp[l] = pw; lo[l] = toff; ls[l] = sz;
         toff += sz;
      end
      for (int l = ft; l < lv; l++) begin
         idx = (l - ft) & 7;
         tx[l] = tmcl_pkg::TAIL_POS[blog][idx].col;
         ty[l] = tmcl_pkg::TAIL_POS[blog][idx].row;
         tp[l] = bw; lo[l] = 0; ls[l] = 4096;
         if (tx[l] + ew[l] > bw || ty[l] + eh[l] > bh) begin
            expected_levels.push_back(layout_error(tmcl_pkg::ST_OVERFLOW));
            return;
         end
      end
      loff = 0;
      for (int l = 0; l < lv; l++) begin
         loff = (loff + 3) & ~64'd3;
         sz = 64'(ew[l]) * eh[l] * bpe;
         if (loff > 64'hFFFF_FFFF || sz > 64'hFFFF_FFFF - loff) begin
            for (int k = 0; k < l; k++) void'(expected_levels.pop_back());
            expected_levels.push_back(layout_error(tmcl_pkg::ST_OVERFLOW));
            return;
         end
         r.elem_width = ew[l]; r.elem_height = eh[l]; r.tile_pitch = tp[l];
         r.tile_offset = lo[l]; r.tile_size = ls[l];
         r.in_tail = (l >= ft); r.tail_col = tx[l]; r.tail_row = ty[l];
         r.lin_offset = loff; r.lin_size = sz;
         r.last_level = (l + 1 == lv); r.status = tmcl_pkg::ST_OK;
         expected_levels.push_back(r);
         loff += sz;
      end
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   function automatic tmcl_pkg::req_payload_type random_desc();
      tmcl_pkg::req_payload_type d;
      int sel, t, w, h;
      int bytes_choice[5] = '{1, 2, 4, 8, 16};
      sel = $urandom_range(0, 9);
      d.format_code = ($urandom_range(0, 3) == 0) ? tmcl_pkg::BC_FORMAT_A :
                      ($urandom_range(0, 3) == 0) ? tmcl_pkg::BC_FORMAT_B : 8'($urandom);
      d.element_bytes = bytes_choice[$urandom_range(0, 4)];
      t = (d.format_code == tmcl_pkg::BC_FORMAT_A ||
           d.format_code == tmcl_pkg::BC_FORMAT_B) ? 4 : 1;
      case ($urandom_range(0, 3))
         0: w = $urandom_range(1, 16384);
         1: w = $urandom_range(1, 256);
         default: w = 1 << $urandom_range(0, 14);
      endcase
      h = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 16384) : 1 << $urandom_range(0, 14);
      d.texel_width = w;
      d.texel_height = h;
      d.row_pitch = ($urandom_range(0, 3) == 0) ? ((w + t - 1) / t) * t : w;
      d.level_count = $urandom_range(1, 15);
      if (sel == 0) d = tmcl_pkg::req_payload_type'({$urandom, $urandom});
      else if (sel == 1) d.element_bytes = $urandom;
      else if (sel == 2) d.row_pitch = $urandom;
      else if (sel == 3) d.level_count = $urandom;
      return d;
   endfunction

   function automatic tmcl_pkg::req_payload_type make_desc(input logic [7:0] f,
      input logic [4:0] b, input logic [14:0] w, input logic [14:0] h,
      input logic [14:0] p, input logic [4:0] l);
      tmcl_pkg::req_payload_type d;
      d.format_code = f; d.element_bytes = b; d.texel_width = w;
      d.texel_height = h; d.row_pitch = p; d.level_count = l;
      return d;
   endfunction

   initial begin
      pending_descs.push_back(make_desc(8'd0, 5'd4, 15'd16384, 15'd16384, 15'd16384, 5'd15));
      pending_descs.push_back(make_desc(8'd0, 5'd16, 15'd16384, 15'd16384, 15'd16384, 5'd15));
      pending_descs.push_back(make_desc(8'd0, 5'd1, 15'd16384, 15'd1, 15'd16384, 5'd15));
      pending_descs.push_back(make_desc(tmcl_pkg::BC_FORMAT_A, 5'd8, 15'd1024, 15'd512,
                                        15'd1023, 5'd11));
      pending_descs.push_back(make_desc(tmcl_pkg::BC_FORMAT_B, 5'd16, 15'd13, 15'd7,
                                        15'd16, 5'd4));
      pending_descs.push_back(make_desc(8'd255, 5'd2, 15'd100, 15'd60, 15'd100, 5'd7));
      pending_descs.push_back(make_desc(8'd1, 5'd4, 15'd1, 15'd1, 15'd1, 5'd1));
      pending_descs.push_back(make_desc(8'd1, 5'd4, 15'd8, 15'd8, 15'd8, 5'd1));
      pending_descs.push_back(make_desc(8'd1, 5'd4, 15'd0, 15'd8, 15'd8, 5'd1));
      pending_descs.push_back(make_desc(8'd1, 5'd4, 15'd8, 15'd0, 15'd8, 5'd1));
      pending_descs.push_back(make_desc(8'd1, 5'd4, 15'd16385, 15'd8, 15'd16385, 5'd1));
      pending_descs.push_back(make_desc(8'd1, 5'd4, 15'd8, 15'h7FFF, 15'd8, 5'd1));
      pending_descs.push_back(make_desc(8'd1, 5'd4, 15'd8, 15'd8, 15'd7, 5'd1));
      pending_descs.push_back(make_desc(8'd1, 5'd4, 15'd8, 15'd8, 15'd9, 5'd1));
      pending_descs.push_back(make_desc(8'd1, 5'd4, 15'd8, 15'd8, 15'd8, 5'd0));
      pending_descs.push_back(make_desc(8'd1, 5'd4, 15'd8, 15'd8, 15'd8, 5'd17));
      pending_descs.push_back(make_desc(8'd1, 5'd4, 15'd8, 15'd8, 15'd8, 5'd5));
      pending_descs.push_back(make_desc(8'd1, 5'd4, 15'd8, 15'd8, 15'd8, 5'd4));
      pending_descs.push_back(make_desc(8'd1, 5'd3, 15'd8, 15'd8, 15'd8, 5'd1));
      pending_descs.push_back(make_desc(8'd1, 5'd0, 15'd8, 15'd8, 15'd8, 5'd1));
      pending_descs.push_back(make_desc(8'd1, 5'd31, 15'd8, 15'd8, 15'd8, 5'd1));
      pending_descs.push_back(make_desc(8'd1, 5'd16, 15'd16384, 15'd16384, 15'd16384, 5'd1));
      pending_descs.push_back(make_desc(8'd1, 5'd16, 15'd16384, 15'd16384, 15'd16384, 5'd2));
      pending_descs.push_back(make_desc(8'd1, 5'd1, 15'd16384, 15'd16384, 15'd16384, 5'd16));
      repeat (290) pending_descs.push_back(random_desc());
   end

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_layout(req_payload);
            accepted_count++;
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_descs.size() > 0) begin
               req_valid <= 1'b1;
               req_payload <= pending_descs.pop_front();
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 12);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 150);
               end
            end else begin
               req_valid <= 1'b0;
               stimulus_done = 1'b1;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_levels.size() == 0) begin
               report_mismatch("unexpected beat", 0, 0);
            end else begin
               tmcl_pkg::rsp_payload_type e;
               e = expected_levels.pop_front();
               if (rsp_payload.elem_width !== e.elem_width)
                  report_mismatch("elem_width", rsp_payload.elem_width, e.elem_width);
               if (rsp_payload.elem_height !== e.elem_height)
                  report_mismatch("elem_height", rsp_payload.elem_height, e.elem_height);
               if (rsp_payload.tile_pitch !== e.tile_pitch)
                  report_mismatch("tile_pitch", rsp_payload.tile_pitch, e.tile_pitch);
               if (rsp_payload.tile_offset !== e.tile_offset)
                  report_mismatch("tile_offset", rsp_payload.tile_offset, e.tile_offset);
               if (rsp_payload.tile_size !== e.tile_size)
                  report_mismatch("tile_size", rsp_payload.tile_size, e.tile_size);
               if (rsp_payload.in_tail !== e.in_tail)
                  report_mismatch("in_tail", rsp_payload.in_tail, e.in_tail);
               if (rsp_payload.tail_col !== e.tail_col)
                  report_mismatch("tail_col", rsp_payload.tail_col, e.tail_col);
               if (rsp_payload.tail_row !== e.tail_row)
                  report_mismatch("tail_row", rsp_payload.tail_row, e.tail_row);
               if (rsp_payload.lin_offset !== e.lin_offset)
                  report_mismatch("lin_offset", rsp_payload.lin_offset, e.lin_offset);
               if (rsp_payload.lin_size !== e.lin_size)
                  report_mismatch("lin_size", rsp_payload.lin_size, e.lin_size);
               if (rsp_payload.last_level !== e.last_level)
                  report_mismatch("last_level", rsp_payload.last_level, e.last_level);
               if (rsp_payload.status !== e.status)
                  report_mismatch("status", rsp_payload.status, e.status);
            end
         end
         // One long hold-off early in the random part lets the block back up.
         if (accepted_count >= 40 && accepted_count < 44 && hold_cycles < 600) begin
            hold_cycles++;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 7) < 2) ? 1'b0 : ($urandom_range(0, 3) != 0);
         end
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      wait (stimulus_done && expected_levels.size() == 0);
      repeat (200) @(posedge clock);
      if (error_count == 0 && expected_levels.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
`default_nettype wire
